>>> sv/sed_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the string escape decoder.
// No dependencies; used by every module of the block.
package sed_pkg;

   localparam int MaxOut = 5;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BSL  = 3'd1,
      MODE_UNI  = 3'd2,
      MODE_HEX  = 3'd3
   } mode_type;

   localparam logic [7:0] CHR_BSL   = 8'h5C;
   localparam logic [7:0] CHR_N     = 8'h6E;
   localparam logic [7:0] CHR_T     = 8'h74;
   localparam logic [7:0] CHR_R     = 8'h72;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_U     = 8'h75;
   localparam logic [7:0] CHR_X     = 8'h78;
   localparam logic [7:0] BYTE_LF   = 8'h0A;
   localparam logic [7:0] BYTE_TAB  = 8'h09;
   localparam logic [7:0] BYTE_CR   = 8'h0D;
   localparam logic [7:0] LEAD2     = 8'hC0;
   localparam logic [7:0] LEAD3     = 8'hE0;
   localparam logic [7:0] CONT      = 8'h80;
   localparam logic [15:0] LIMIT1   = 16'h007F;
   localparam logic [15:0] LIMIT2   = 16'h07FF;

   // decoded bytes of one item, lowest index goes out first
   typedef struct packed {
      logic [MaxOut-1:0][7:0] data;
      logic [2:0]             cnt;
      logic                   last;
   } group_type;

   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      cnt;
   } enc_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       idle;
      logic [1:0] digits;
   } dec_status_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         h.ok  = 1'b1;
         h.val = 4'(b[3:0] + 4'd9);
      end
      return h;
   endfunction

   // modified UTF-8, code point zero as the two-byte form
   function automatic enc_type encode(input logic [15:0] cp);
      enc_type e;
      e = '0;
      if (cp == 16'h0000) begin
         e.data[0] = LEAD2;
         e.data[1] = CONT;
         e.cnt     = 2'd2;
      end else if (cp <= LIMIT1) begin
         e.data[0] = cp[7:0];
         e.cnt     = 2'd1;
      end else if (cp <= LIMIT2) begin
         e.data[0] = LEAD2 | {3'b000, cp[10:6]};
         e.data[1] = CONT | {2'b00, cp[5:0]};
         e.cnt     = 2'd2;
      end else begin
         e.data[0] = LEAD3 | {4'b0000, cp[15:12]};
         e.data[1] = CONT | {2'b00, cp[11:6]};
         e.data[2] = CONT | {2'b00, cp[5:0]};
         e.cnt     = 2'd3;
      end
      return e;
   endfunction

endpackage

>>> sv/sed_decode.sv
`timescale 1ns / 1ps
// Escape state and single-pass decode of one registered input byte into a group.
// Depends on sed_pkg.
module sed_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [7:0]               in_byte,
   input  logic                     in_last,
   output sed_pkg::group_type       group,
   output sed_pkg::dec_status_type  status
);

   sed_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [15:0]       code_ff, code_in;
   logic [2:0][7:0]   held_ff, held_in;

   sed_pkg::group_type res;
   sed_pkg::hex_type   hd;
   sed_pkg::enc_type   enc;
   logic [2:0]         n;
   logic [7:0]         letter;
   logic               full;
   logic [15:0]        code_next;

   always_comb begin
      res       = '0;
      n         = 3'd0;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      code_in   = code_ff;
      held_in   = held_ff;
      hd        = sed_pkg::hex_digit(in_byte);
      code_next = {code_ff[11:0], hd.val};
      enc       = sed_pkg::encode(code_next);
      letter    = (mode_ff == sed_pkg::MODE_UNI) ? sed_pkg::CHR_U : sed_pkg::CHR_X;
      full      = (mode_ff == sed_pkg::MODE_UNI) ? (cnt_ff == 2'd3) : (cnt_ff != 2'd0);

      case (mode_ff)
         sed_pkg::MODE_BSL: begin
            mode_in = sed_pkg::MODE_IDLE;
            if (in_byte == sed_pkg::CHR_N) begin
               res.data[n] = sed_pkg::BYTE_LF;
               n = n + 3'd1;
            end else if (in_byte == sed_pkg::CHR_T) begin
               res.data[n] = sed_pkg::BYTE_TAB;
               n = n + 3'd1;
            end else if (in_byte == sed_pkg::CHR_R) begin
               res.data[n] = sed_pkg::BYTE_CR;
               n = n + 3'd1;
            end else if (in_byte == sed_pkg::CHR_ZERO) begin
               res.data[n] = sed_pkg::LEAD2;
               n = n + 3'd1;
               res.data[n] = sed_pkg::CONT;
               n = n + 3'd1;
            end else if (in_byte == sed_pkg::CHR_U || in_byte == sed_pkg::CHR_X) begin
               cnt_in  = 2'd0;
               code_in = 16'h0000;
               if (in_last) begin
                  res.data[n] = in_byte;
                  n = n + 3'd1;
               end else begin
                  mode_in = (in_byte == sed_pkg::CHR_U) ? sed_pkg::MODE_UNI
                                                        : sed_pkg::MODE_HEX;
               end
            end else begin
               res.data[n] = in_byte;
               n = n + 3'd1;
            end
         end
         sed_pkg::MODE_UNI, sed_pkg::MODE_HEX: begin
            if (!hd.ok) begin
               // broken escape: letter and held digits, then the byte afresh
               res.data[n] = letter;
               n = n + 3'd1;
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < cnt_ff) begin
                     res.data[n] = held_ff[k];
                     n = n + 3'd1;
                  end
               end
               mode_in = sed_pkg::MODE_IDLE;
               cnt_in  = 2'd0;
               code_in = 16'h0000;
               if (in_byte == sed_pkg::CHR_BSL && !in_last) begin
                  mode_in = sed_pkg::MODE_BSL;
               end else begin
                  res.data[n] = in_byte;
                  n = n + 3'd1;
               end
            end else if (full) begin
               for (int k = 0; k < 3; k++) begin
                  if (2'(k) < enc.cnt) begin
                     res.data[n] = enc.data[k];
                     n = n + 3'd1;
                  end
               end
               mode_in = sed_pkg::MODE_IDLE;
               cnt_in  = 2'd0;
               code_in = 16'h0000;
            end else begin
               held_in[cnt_ff] = in_byte;
               cnt_in          = cnt_ff + 2'd1;
               code_in         = code_next;
               if (in_last) begin
                  res.data[n] = letter;
                  n = n + 3'd1;
                  for (int k = 0; k < 3; k++) begin
                     if (2'(k) < cnt_ff) begin
                        res.data[n] = held_ff[k];
                        n = n + 3'd1;
                     end
                  end
                  res.data[n] = in_byte;
                  n = n + 3'd1;
               end
            end
         end
         default: begin
            mode_in = sed_pkg::MODE_IDLE;
            if (in_byte == sed_pkg::CHR_BSL && !in_last) begin
               mode_in = sed_pkg::MODE_BSL;
            end else begin
               res.data[n] = in_byte;
               n = n + 3'd1;
            end
         end
      endcase

      if (in_last) begin
         mode_in = sed_pkg::MODE_IDLE;
         cnt_in  = 2'd0;
         code_in = 16'h0000;
      end
      res.cnt  = n;
      res.last = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sed_pkg::MODE_IDLE;
         cnt_ff  <= 2'd0;
         code_ff <= 16'h0000;
      end else if (load) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         code_ff <= code_in;
      end
   end

   // held digits are only read below the digit count, so no reset
   always_ff @(posedge clock) begin
      if (load) begin
         held_ff <= held_in;
      end
   end

   assign group         = res;
   assign status.idle   = (mode_ff == sed_pkg::MODE_IDLE);
   assign status.digits = cnt_ff;

endmodule

>>> sv/sed_serial.sv
`timescale 1ns / 1ps
// Result register holding one decoded group, shifted out a byte per cycle unless stalled.
// Depends on sed_pkg.
module sed_serial (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  sed_pkg::group_type group,
   output logic               free,
   output logic [2:0]         count,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   logic [sed_pkg::MaxOut-1:0][7:0] data_ff;
   logic [2:0]                      cnt_ff;
   logic                            last_ff;
   logic                            take;

   assign take = (cnt_ff != 3'd0) && rsp_tready;
   // group empty, or its final byte leaves this cycle
   assign free = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (load) begin
         cnt_ff <= group.cnt;
      end else if (take) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= group.data;
         last_ff <= group.last;
      end else if (take) begin
         data_ff <= {8'h00, data_ff[sed_pkg::MaxOut-1:1]};
      end
   end

   assign count      = cnt_ff;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = last_ff && (cnt_ff == 3'd1);

endmodule

>>> sv/string_escape_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the string escape decoder: input register, decode, result serialiser.
// Depends on sed_pkg, sed_decode and sed_serial.
//
//  channel | direction | tdata      | tlast    | tuser
//  req_    | in        | in_byte    | is_last  | -
//  rsp_    | out       | out_byte   | out_last | -
//
// An item waits in the input register, is decoded in one pass and its 0 to 5
// bytes are loaded together into the result register, which sends the first byte out.
// The rate is one item per cycle while each yields at most one byte and the output does
// not stall; a longer group holds the next item in the input register until it drains.
// Synchronous reset returns the escape state to idle and empties both registers.
// A stalled output holds the group; the input register still takes one more item.
module string_escape_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   logic                    in_vld_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   logic                    grp_free;
   logic                    grp_load;
   logic [2:0]              grp_count;
   sed_pkg::group_type      group;
   sed_pkg::dec_status_type dec_status;

   assign grp_load   = in_vld_ff && grp_free;
   assign req_tready = !in_vld_ff || grp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   sed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .load    (grp_load),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .group   (group),
      .status  (dec_status)
   );

   sed_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (grp_load),
      .group      (group),
      .free       (grp_free),
      .count      (grp_count),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      grp_count <= 3'(sed_pkg::MaxOut))
      else $error("result group holds more bytes than an item can yield");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> grp_count == 3'd1)
      else $error("last marker on a byte that is not the final one of its group");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      grp_load && in_last_ff |=> dec_status.idle && dec_status.digits == 2'd0)
      else $error("escape state not cleared after the final byte of a literal");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      grp_load |-> grp_count <= 3'd1)
      else $error("group loaded over bytes still waiting");

endmodule

>>> bench/string_escape_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for string_escape_decoder_unit: directed escapes, random literals
// under several idle and stall mixes, and a long output hold-off. Depends on sed_pkg.
module string_escape_decoder_unit_test;

   localparam int QuietLimit = 2000;   // cycles with no handshake before giving up
   localparam int PhaseItems = 45;
   localparam int HoldCycles = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;         // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;              // [7:0] out_byte
   logic       rsp_tlast;

   out_item_type pending_bytes[$];
   logic [7:0] literal_bytes[$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_len = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         phase_items = 0;

   // decoder state as predicted
   sed_pkg::mode_type esc_mode = sed_pkg::MODE_IDLE;
   logic [1:0] esc_digits = '0;
   logic [15:0] esc_code = '0;
   logic [7:0] esc_held[0:2] = '{default: 8'h00};
   logic [7:0] dec_buf[0:sed_pkg::MaxOut-1];
   int         dec_n;

   always #5 clock = ~clock;

   string_escape_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // bit 4 set when the byte is a hex digit, value below
   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      logic [7:0] v;
      v = '0;
      if (b >= 8'h30 && b <= 8'h39) v = b - 8'h30;
      else if (b >= 8'h61 && b <= 8'h66) v = b - 8'h57;
      else if (b >= 8'h41 && b <= 8'h46) v = b - 8'h37;
      else return 5'b0;
      return {1'b1, v[3:0]};
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(21);
      if (v < 10) return 8'(8'h30 + v);
      if (v < 16) return 8'(8'h61 + v - 10);
      return 8'(8'h41 + v - 16);
   endfunction

   task automatic put_byte(input logic [7:0] v);
      if (dec_n < sed_pkg::MaxOut) begin
         dec_buf[dec_n] = v;
         dec_n++;
      end
   endtask

   // modified UTF-8, zero as the overlong pair
   task automatic put_code(input logic [15:0] cp);
      if (cp == 16'h0000) begin
         put_byte(sed_pkg::LEAD2);
         put_byte(sed_pkg::CONT);
      end else if (cp <= sed_pkg::LIMIT1) begin
         put_byte(cp[7:0]);
      end else if (cp <= sed_pkg::LIMIT2) begin
         put_byte(sed_pkg::LEAD2 | {3'b000, cp[10:6]});
         put_byte(sed_pkg::CONT | {2'b00, cp[5:0]});
      end else begin
         put_byte(sed_pkg::LEAD3 | {4'b0000, cp[15:12]});
         put_byte(sed_pkg::CONT | {2'b00, cp[11:6]});
         put_byte(sed_pkg::CONT | {2'b00, cp[5:0]});
      end
   endtask

   task automatic flush_digits();
      put_byte((esc_mode == sed_pkg::MODE_UNI) ? sed_pkg::CHR_U : sed_pkg::CHR_X);
      for (int k = 0; k < int'(esc_digits); k++) put_byte(esc_held[k]);
   endtask

   task automatic clear_escape();
      esc_mode   = sed_pkg::MODE_IDLE;
      esc_digits = '0;
      esc_code   = '0;
   endtask

   task automatic plain_byte(input logic [7:0] b, input logic l);
      if (b == sed_pkg::CHR_BSL && !l) esc_mode = sed_pkg::MODE_BSL;
      else put_byte(b);
   endtask

   task automatic decode_item(input logic [7:0] b, input logic l);
      int need;
      logic [4:0] nib;
      out_item_type item;
      dec_n = 0;
      case (esc_mode)
         sed_pkg::MODE_BSL: begin
            esc_mode = sed_pkg::MODE_IDLE;
            if (b == sed_pkg::CHR_N) put_byte(sed_pkg::BYTE_LF);
            else if (b == sed_pkg::CHR_T) put_byte(sed_pkg::BYTE_TAB);
            else if (b == sed_pkg::CHR_R) put_byte(sed_pkg::BYTE_CR);
            else if (b == sed_pkg::CHR_ZERO) put_code(16'h0000);
            else if (b == sed_pkg::CHR_U || b == sed_pkg::CHR_X) begin
               esc_digits = '0;
               esc_code   = '0;
               if (l) put_byte(b);
               else esc_mode = (b == sed_pkg::CHR_U) ? sed_pkg::MODE_UNI
                                                      : sed_pkg::MODE_HEX;
            end else put_byte(b);
         end
         sed_pkg::MODE_UNI, sed_pkg::MODE_HEX: begin
            need = (esc_mode == sed_pkg::MODE_UNI) ? 4 : 2;
            nib  = nibble_of(b);
            if (!nib[4]) begin
               // broken escape: letter and digits go out, breaker handled as idle
               flush_digits();
               clear_escape();
               plain_byte(b, l);
            end else if (int'(esc_digits) + 1 >= need) begin
               put_code({esc_code[11:0], nib[3:0]});
               clear_escape();
            end else begin
               esc_held[esc_digits] = b;
               esc_digits = esc_digits + 2'd1;
               esc_code   = {esc_code[11:0], nib[3:0]};
               if (l) flush_digits();
            end
         end
         default: begin
            esc_mode = sed_pkg::MODE_IDLE;
            plain_byte(b, l);
         end
      endcase
      if (l) clear_escape();
      for (int k = 0; k < dec_n; k++) begin
         item.data = dec_buf[k];
         item.last = l && (k == dec_n - 1);
         pending_bytes.push_back(item);
      end
   endtask

   task automatic check_result(input logic [7:0] data, input logic last);
      out_item_type want;
      if (pending_bytes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected item: got %02h last %0b", data, last);
      end else begin
         want = pending_bytes.pop_front();
         if (want.data !== data || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %02h last %0b, got %02h last %0b",
                        want.data, want.last, data, last);
         end
      end
   endtask

   // prediction and checking, both sampled at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) decode_item(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (hold_len != 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("FAIL string_escape_decoder_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tlast  <= 1'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      phase_items++;
   endtask

   task automatic send_literal();
      for (int k = 0; k < literal_bytes.size(); k++)
         send_item(literal_bytes[k], k == literal_bytes.size() - 1);
      literal_bytes.delete();
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // one piece of a literal: plain byte, escape, hex escape, broken escape or lone backslash
   task automatic add_piece();
      int r;
      int cnt;
      logic [7:0] letter;
      r = $urandom_range(99);
      if (r < 30) begin
         literal_bytes.push_back(8'($urandom));
      end else if (r < 45) begin
         literal_bytes.push_back(sed_pkg::CHR_BSL);
         case ($urandom_range(4))
            0: literal_bytes.push_back(sed_pkg::CHR_N);
            1: literal_bytes.push_back(sed_pkg::CHR_T);
            2: literal_bytes.push_back(sed_pkg::CHR_R);
            3: literal_bytes.push_back(sed_pkg::CHR_ZERO);
            default: literal_bytes.push_back(8'($urandom));
         endcase
      end else if (r < 80) begin
         letter = (r < 65) ? sed_pkg::CHR_U : sed_pkg::CHR_X;
         cnt    = (letter == sed_pkg::CHR_U) ? 4 : 2;
         literal_bytes.push_back(sed_pkg::CHR_BSL);
         literal_bytes.push_back(letter);
         repeat (cnt) literal_bytes.push_back(hex_char());
      end else if (r < 92) begin
         letter = $urandom_range(1) ? sed_pkg::CHR_U : sed_pkg::CHR_X;
         cnt    = $urandom_range((letter == sed_pkg::CHR_U) ? 3 : 1);
         literal_bytes.push_back(sed_pkg::CHR_BSL);
         literal_bytes.push_back(letter);
         repeat (cnt) literal_bytes.push_back(hex_char());
         literal_bytes.push_back(8'($urandom));
      end else begin
         literal_bytes.push_back(sed_pkg::CHR_BSL);
      end
   endtask

   task automatic test_escapes();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_N, 1'b0);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_T, 1'b0);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_R, 1'b1);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_ZERO, 1'b0);
      // \x00 encodes as the zero pair
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_X, 1'b0);
      send_item("0", 1'b0); send_item("0", 1'b1);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_U, 1'b0);
      send_item("F", 1'b0); send_item("f", 1'b0); send_item("F", 1'b0); send_item("f", 1'b1);
      // broken \u, the backslash starts a new escape of an ordinary character
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_U, 1'b0);
      send_item("1", 1'b0); send_item("2", 1'b0);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item("q", 1'b0);
      // trailing backslash
      send_item(sed_pkg::CHR_BSL, 1'b1);
      // escapes cut short by the end of the literal
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_X, 1'b0);
      send_item("A", 1'b1);
      send_item(sed_pkg::CHR_BSL, 1'b0); send_item(sed_pkg::CHR_U, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      phase_items    = 0;
      while (phase_items < PhaseItems) begin
         repeat ($urandom_range(6, 1)) add_piece();
         send_literal();
      end
      wait_for_results();
   endtask

   // output held off while three-byte escapes keep arriving, so the input stalls
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_len       = HoldCycles;
      repeat (8) begin
         literal_bytes.push_back(sed_pkg::CHR_BSL);
         literal_bytes.push_back(sed_pkg::CHR_U);
         literal_bytes.push_back(8'(8'h38 + $urandom_range(1)));
         repeat (3) literal_bytes.push_back(hex_char());
      end
      send_literal();
      wait_for_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_escapes();
      test_random_traffic(0, 0);
      test_random_traffic(47, 0);
      test_random_traffic(0, 47);
      test_random_traffic(25, 25);
      test_backpressure();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("PASS string_escape_decoder_unit");
      end else begin
         $display("FAIL string_escape_decoder_unit");
      end
      $finish;
   end

endmodule

>>> string_escape_decoder_unit.f
sv/sed_pkg.sv
sv/sed_decode.sv
sv/sed_serial.sv
sv/string_escape_decoder_unit.sv
bench/string_escape_decoder_unit_test.sv
